FILE: src/lf_wakeup_frame_gate_generator_core_assert.svh
`ifndef LF_WAKEUP_FRAME_GATE_GENERATOR_CORE_ASSERT_SVH
`define LF_WAKEUP_FRAME_GATE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define LFWG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfwg assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define LFWG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfwg assertion failed");

`endif

FILE: src/lfwg_pkg.sv
package lfwg_pkg;

   // Frame phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_BURST   = 3'd1;
   localparam logic [2:0] PH_SEP     = 3'd2;
   localparam logic [2:0] PH_PRE_ON  = 3'd3;
   localparam logic [2:0] PH_PRE_OFF = 3'd4;
   localparam logic [2:0] PH_BIT_A   = 3'd5;
   localparam logic [2:0] PH_BIT_B   = 3'd6;
   localparam logic [2:0] PH_GAP     = 3'd7;

   // Register indexes (byte address is 4 times the index)
   localparam logic [2:0] REG_BURST_LEN       = 3'd0;
   localparam logic [2:0] REG_SEPARATION_LEN  = 3'd1;
   localparam logic [2:0] REG_FIRST_HALF_LEN  = 3'd2;
   localparam logic [2:0] REG_SECOND_HALF_LEN = 3'd3;
   localparam logic [2:0] REG_PREAMBLE_PAIRS  = 3'd4;
   localparam logic [2:0] REG_FRAME_GAP_LEN   = 3'd5;
   localparam logic [2:0] REG_ASYNC_MODE      = 3'd6;

   localparam int unsigned ADDR_WIDTH = 5;
   localparam int unsigned DATA_WIDTH = 32;

   // Register reset values
   localparam logic [15:0] BURST_LEN_RST       = 16'd2020;
   localparam logic [15:0] SEPARATION_LEN_RST  = 16'd360;
   localparam logic [11:0] FIRST_HALF_LEN_RST  = 12'd348;
   localparam logic [11:0] SECOND_HALF_LEN_RST = 12'd360;
   localparam logic [7:0]  PREAMBLE_PAIRS_RST  = 8'd4;
   localparam logic [20:0] FRAME_GAP_LEN_RST   = 21'd1500000;
   localparam logic        ASYNC_MODE_RST      = 1'b1;

endpackage

FILE: src/lf_wakeup_frame_gate_generator_core.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_send_request, req_pattern
// rsp      out        rsp_valid / rsp_stall  rsp_carrier_on, rsp_busy_res,
//                                            rsp_request_dropped, rsp_frame_done
// csr      in         psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One item per cycle while req_stall is low: each tick's result is
// registered, and rsp_valid rises in the cycle after acceptance.
// The result register is the only output buffer; req_stall rises only while a
// result is held by rsp_stall. Synchronous active-high reset returns the
// frame sequencer to idle, empties the pending slot and loads register
// defaults; no clearing pass is needed.
`include "lf_wakeup_frame_gate_generator_core_assert.svh"

module lf_wakeup_frame_gate_generator_core #(
   parameter int unsigned PATTERN_BITS   = 16,
   parameter int unsigned GAP_COUNT_BITS = 21
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_send_request,
   input  logic [PATTERN_BITS-1:0]             req_pattern,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_carrier_on,
   output logic                                rsp_busy_res,
   output logic                                rsp_request_dropped,
   output logic                                rsp_frame_done,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lfwg_pkg::ADDR_WIDTH-1:0]     paddr,
   input  logic [lfwg_pkg::DATA_WIDTH-1:0]     pwdata,
   output logic [lfwg_pkg::DATA_WIDTH-1:0]     prdata,
   output logic                                pready
);

   localparam int unsigned TW = GAP_COUNT_BITS;
   localparam int unsigned BW = $clog2(PATTERN_BITS + 1);
   localparam logic [31:0] GAP_MAX = 32'((64'd1 << GAP_COUNT_BITS) - 64'd1);

   // configuration registers
   logic [15:0] burst_len_ff;
   logic [15:0] separation_len_ff;
   logic [11:0] first_half_len_ff;
   logic [11:0] second_half_len_ff;
   logic [7:0]  preamble_pairs_ff;
   logic [20:0] frame_gap_len_ff;
   logic        async_mode_ff;

   // sequencer state
   logic [2:0]              phase_ff,   phase_in;
   logic [TW-1:0]           ticks_ff,   ticks_in;
   logic [PATTERN_BITS-1:0] shift_ff,   shift_in;
   logic [BW-1:0]           bits_ff,    bits_in;
   logic [7:0]              pairs_ff,   pairs_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic [PATTERN_BITS-1:0] pend_pat_ff, pend_pat_in;

   // result register
   logic rsp_valid_ff;
   logic carrier_ff,   carrier_in;
   logic busy_ff,      busy_in;
   logic dropped_ff,   dropped_in;
   logic done_ff,      done_in;

   logic          in_take;
   logic          cfg_wr;
   logic [2:0]    cfg_idx;
   logic [TW-1:0] burst_ticks;
   logic [TW-1:0] sep_ticks;
   logic [TW-1:0] first_ticks;
   logic [TW-1:0] second_ticks;
   logic [TW-1:0] gap_ticks;
   logic [31:0]   gap_wide;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign in_take   = req_valid & ~req_stall;

   assign cfg_wr  = psel & penable & pwrite & pready;
   assign cfg_idx = paddr[4:2];
   assign pready  = 1'b1;

   // segment lengths, zero counts as one tick
   assign burst_ticks  = (burst_len_ff == '0) ? TW'(1) : TW'(burst_len_ff);
   assign sep_ticks    = (separation_len_ff == '0) ? TW'(1) : TW'(separation_len_ff);
   assign first_ticks  = (first_half_len_ff == '0) ? TW'(1) : TW'(first_half_len_ff);
   assign second_ticks = (second_half_len_ff == '0) ? TW'(1) : TW'(second_half_len_ff);

   // saturate the gap to the counter width
   assign gap_wide  = 32'(frame_gap_len_ff);
   assign gap_ticks = (gap_wide > GAP_MAX) ? {TW{1'b1}} : gap_wide[TW-1:0];

   always_comb begin
      phase_in    = phase_ff;
      ticks_in    = ticks_ff;
      shift_in    = shift_ff;
      bits_in     = bits_ff;
      pairs_in    = pairs_ff;
      pend_vld_in = pend_vld_ff;
      pend_pat_in = pend_pat_ff;
      carrier_in  = 1'b0;
      busy_in     = 1'b0;
      dropped_in  = 1'b0;
      done_in     = 1'b0;

      // launch a held request first
      if (phase_in == lfwg_pkg::PH_IDLE && pend_vld_in) begin
         shift_in    = pend_pat_in;
         bits_in     = BW'(PATTERN_BITS);
         pairs_in    = '0;
         phase_in    = lfwg_pkg::PH_BURST;
         ticks_in    = burst_ticks;
         pend_vld_in = 1'b0;
      end

      if (req_send_request) begin
         if (phase_in == lfwg_pkg::PH_IDLE) begin
            shift_in = req_pattern;
            bits_in  = BW'(PATTERN_BITS);
            pairs_in = '0;
            phase_in = lfwg_pkg::PH_BURST;
            ticks_in = burst_ticks;
         end else if (async_mode_ff) begin
            dropped_in = 1'b1;
         end else if (!pend_vld_in) begin
            pend_vld_in = 1'b1;
            pend_pat_in = req_pattern;
         end else begin
            dropped_in = 1'b1;
         end
      end

      if (phase_in != lfwg_pkg::PH_IDLE) begin
         busy_in = 1'b1;
         case (phase_in)
            lfwg_pkg::PH_BURST:  carrier_in = 1'b1;
            lfwg_pkg::PH_PRE_ON: carrier_in = 1'b1;
            lfwg_pkg::PH_BIT_A:  carrier_in = ~shift_in[PATTERN_BITS-1];
            lfwg_pkg::PH_BIT_B:  carrier_in = shift_in[PATTERN_BITS-1];
            default:             carrier_in = 1'b0;
         endcase
         if (ticks_in != '0) begin
            ticks_in = ticks_in - TW'(1);
         end
         // segment ends: load the next one
         if (ticks_in == '0) begin
            case (phase_in)
               lfwg_pkg::PH_BURST: begin
                  phase_in = lfwg_pkg::PH_SEP;
                  ticks_in = sep_ticks;
               end
               lfwg_pkg::PH_SEP: begin
                  pairs_in = preamble_pairs_ff;
                  if (preamble_pairs_ff != '0) begin
                     phase_in = lfwg_pkg::PH_PRE_ON;
                     ticks_in = first_ticks;
                  end else begin
                     phase_in = lfwg_pkg::PH_BIT_A;
                     ticks_in = first_ticks;
                  end
               end
               lfwg_pkg::PH_PRE_ON: begin
                  phase_in = lfwg_pkg::PH_PRE_OFF;
                  ticks_in = second_ticks;
               end
               lfwg_pkg::PH_PRE_OFF: begin
                  if (pairs_in != '0) begin
                     pairs_in = pairs_in - 8'd1;
                  end
                  if (pairs_in != '0) begin
                     phase_in = lfwg_pkg::PH_PRE_ON;
                  end else begin
                     phase_in = lfwg_pkg::PH_BIT_A;
                  end
                  ticks_in = first_ticks;
               end
               lfwg_pkg::PH_BIT_A: begin
                  phase_in = lfwg_pkg::PH_BIT_B;
                  ticks_in = second_ticks;
               end
               lfwg_pkg::PH_BIT_B: begin
                  if (bits_in != '0) begin
                     bits_in = bits_in - BW'(1);
                  end
                  shift_in = {shift_in[PATTERN_BITS-2:0], 1'b0};
                  if (bits_in != '0) begin
                     phase_in = lfwg_pkg::PH_BIT_A;
                     ticks_in = first_ticks;
                  end else begin
                     done_in = 1'b1;
                     if (gap_ticks == '0) begin
                        phase_in = lfwg_pkg::PH_IDLE;
                        ticks_in = '0;
                     end else begin
                        phase_in = lfwg_pkg::PH_GAP;
                        ticks_in = gap_ticks;
                     end
                  end
               end
               default: begin
                  phase_in = lfwg_pkg::PH_IDLE;
                  ticks_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= lfwg_pkg::PH_IDLE;
         ticks_ff    <= '0;
         shift_ff    <= '0;
         bits_ff     <= '0;
         pairs_ff    <= '0;
         pend_vld_ff <= 1'b0;
      end else if (in_take) begin
         phase_ff    <= phase_in;
         ticks_ff    <= ticks_in;
         shift_ff    <= shift_in;
         bits_ff     <= bits_in;
         pairs_ff    <= pairs_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         pend_pat_ff <= pend_pat_in;
         carrier_ff  <= carrier_in;
         busy_ff     <= busy_in;
         dropped_ff  <= dropped_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_len_ff       <= lfwg_pkg::BURST_LEN_RST;
         separation_len_ff  <= lfwg_pkg::SEPARATION_LEN_RST;
         first_half_len_ff  <= lfwg_pkg::FIRST_HALF_LEN_RST;
         second_half_len_ff <= lfwg_pkg::SECOND_HALF_LEN_RST;
         preamble_pairs_ff  <= lfwg_pkg::PREAMBLE_PAIRS_RST;
         frame_gap_len_ff   <= lfwg_pkg::FRAME_GAP_LEN_RST;
         async_mode_ff      <= lfwg_pkg::ASYNC_MODE_RST;
      end else if (cfg_wr) begin
         case (cfg_idx)
            lfwg_pkg::REG_BURST_LEN:       burst_len_ff       <= pwdata[15:0];
            lfwg_pkg::REG_SEPARATION_LEN:  separation_len_ff  <= pwdata[15:0];
            lfwg_pkg::REG_FIRST_HALF_LEN:  first_half_len_ff  <= pwdata[11:0];
            lfwg_pkg::REG_SECOND_HALF_LEN: second_half_len_ff <= pwdata[11:0];
            lfwg_pkg::REG_PREAMBLE_PAIRS:  preamble_pairs_ff  <= pwdata[7:0];
            lfwg_pkg::REG_FRAME_GAP_LEN:   frame_gap_len_ff   <= pwdata[20:0];
            lfwg_pkg::REG_ASYNC_MODE:      async_mode_ff      <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         lfwg_pkg::REG_BURST_LEN:       prdata = 32'(burst_len_ff);
         lfwg_pkg::REG_SEPARATION_LEN:  prdata = 32'(separation_len_ff);
         lfwg_pkg::REG_FIRST_HALF_LEN:  prdata = 32'(first_half_len_ff);
         lfwg_pkg::REG_SECOND_HALF_LEN: prdata = 32'(second_half_len_ff);
         lfwg_pkg::REG_PREAMBLE_PAIRS:  prdata = 32'(preamble_pairs_ff);
         lfwg_pkg::REG_FRAME_GAP_LEN:   prdata = 32'(frame_gap_len_ff);
         lfwg_pkg::REG_ASYNC_MODE:      prdata = 32'(async_mode_ff);
         default:                       prdata = '0;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_carrier_on      = carrier_ff;
   assign rsp_busy_res        = busy_ff;
   assign rsp_request_dropped = dropped_ff;
   assign rsp_frame_done      = done_ff;

   `LFWG_ASSERT_NOW(a_idle_quiet, clock, reset,
      rsp_valid_ff && !busy_ff, !carrier_ff && !done_ff)
   `LFWG_ASSERT_NOW(a_drop_only_busy, clock, reset,
      rsp_valid_ff && dropped_ff, busy_ff)
   `LFWG_ASSERT_NOW(a_idle_no_count, clock, reset,
      phase_ff == lfwg_pkg::PH_IDLE, ticks_ff == '0)
   `LFWG_ASSERT_NOW(a_bits_left, clock, reset,
      phase_ff == lfwg_pkg::PH_BIT_A || phase_ff == lfwg_pkg::PH_BIT_B, bits_ff != '0)
   `LFWG_ASSERT_NEXT(a_take_shows, clock, reset,
      in_take, rsp_valid_ff)

endmodule
